### rtl/rtsf_pkg.sv
`timescale 1ns / 1ps

package rtsf_pkg;

  localparam int SCREEN_COLS = 320;
  localparam int SCREEN_ROWS = 240;

  localparam int RAW_W   = 12;
  localparam int PRESS_W = 13;
  localparam int SX_W    = 9;
  localparam int SY_W    = 8;
  localparam int TOP_W   = 12;
  localparam int PROD_W  = RAW_W + TOP_W;
  localparam int DIV_STEPS = TOP_W;
  localparam int AXIS_LAT  = DIV_STEPS + 3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = PRESS_W;

  localparam logic [TOP_W-1:0] COL_TOP = TOP_W'(SCREEN_COLS - 1);
  localparam logic [TOP_W-1:0] ROW_TOP = TOP_W'(SCREEN_ROWS - 1);

  localparam logic [PRESS_W-1:0] PRESS_OFFSET = PRESS_W'(4095);

  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_CAL_LOW          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_CAL_HIGH         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_LOW          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_CAL_HIGH         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X           = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y           = 3'd6;

  localparam logic [PRESS_W-1:0] RST_PRESSURE_THRESHOLD = PRESS_W'(400);
  localparam logic [RAW_W-1:0]   RST_X_CAL_LOW          = RAW_W'(200);
  localparam logic [RAW_W-1:0]   RST_X_CAL_HIGH         = RAW_W'(3700);
  localparam logic [RAW_W-1:0]   RST_Y_CAL_LOW          = RAW_W'(240);
  localparam logic [RAW_W-1:0]   RST_Y_CAL_HIGH         = RAW_W'(3800);

  typedef struct packed {
    logic [PRESS_W-1:0] pressure_threshold;
    logic [RAW_W-1:0]   x_cal_low;
    logic [RAW_W-1:0]   x_cal_high;
    logic [RAW_W-1:0]   y_cal_low;
    logic [RAW_W-1:0]   y_cal_high;
    logic               mirror_x;
    logic               mirror_y;
  } cfg_t;

  typedef struct packed {
    logic             pen_down;
    logic [RAW_W-1:0] z1_reading;
    logic [RAW_W-1:0] z2_reading;
    logic [RAW_W-1:0] x_first;
    logic [RAW_W-1:0] x_second;
    logic [RAW_W-1:0] x_third;
    logic [RAW_W-1:0] y_first;
    logic [RAW_W-1:0] y_second;
    logic [RAW_W-1:0] y_third;
  } sample_t;

  typedef struct packed {
    logic               valid;
    logic               touched;
    logic [PRESS_W-1:0] pressure;
    logic [RAW_W-1:0]   filtered_x;
    logic [RAW_W-1:0]   filtered_y;
  } meta_t;

endpackage

### rtl/rtsf_in_if.sv
`timescale 1ns / 1ps

interface rtsf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       pen_down;
  logic [rtsf_pkg::RAW_W-1:0] z1_reading;
  logic [rtsf_pkg::RAW_W-1:0] z2_reading;
  logic [rtsf_pkg::RAW_W-1:0] x_first;
  logic [rtsf_pkg::RAW_W-1:0] x_second;
  logic [rtsf_pkg::RAW_W-1:0] x_third;
  logic [rtsf_pkg::RAW_W-1:0] y_first;
  logic [rtsf_pkg::RAW_W-1:0] y_second;
  logic [rtsf_pkg::RAW_W-1:0] y_third;

  modport source (
    output valid, pen_down, z1_reading, z2_reading,
           x_first, x_second, x_third, y_first, y_second, y_third,
    input  ready
  );

  modport sink (
    input  valid, pen_down, z1_reading, z2_reading,
           x_first, x_second, x_third, y_first, y_second, y_third,
    output ready
  );
endinterface

### rtl/rtsf_out_if.sv
`timescale 1ns / 1ps

interface rtsf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         touched;
  logic [rtsf_pkg::SX_W-1:0]    screen_x;
  logic [rtsf_pkg::SY_W-1:0]    screen_y;
  logic [rtsf_pkg::RAW_W-1:0]   filtered_x;
  logic [rtsf_pkg::RAW_W-1:0]   filtered_y;
  logic [rtsf_pkg::PRESS_W-1:0] pressure;

  modport source (
    output valid, touched, screen_x, screen_y, filtered_x, filtered_y, pressure,
    input  ready
  );

  modport sink (
    input  valid, touched, screen_x, screen_y, filtered_x, filtered_y, pressure,
    output ready
  );
endinterface

### rtl/rtsf_cfg_if.sv
`timescale 1ns / 1ps

interface rtsf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rtsf_pkg::CFG_IDX_W-1:0]  index;
  logic [rtsf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rtsf_front.sv
`timescale 1ns / 1ps

module rtsf_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  rtsf_pkg::sample_t                sample,
  input  logic [rtsf_pkg::PRESS_W-1:0]     threshold,
  output rtsf_pkg::meta_t                  meta
);

  logic              s1_valid;
  rtsf_pkg::sample_t s1;
  rtsf_pkg::meta_t   meta_next;
  logic [rtsf_pkg::PRESS_W-1:0] press;
  logic              touched;

  function automatic logic [rtsf_pkg::RAW_W-1:0] pair_mean(
    input logic [rtsf_pkg::RAW_W-1:0] p,
    input logic [rtsf_pkg::RAW_W-1:0] q,
    input logic [rtsf_pkg::RAW_W-1:0] r
  );
    logic [rtsf_pkg::RAW_W-1:0] dpq;
    logic [rtsf_pkg::RAW_W-1:0] dpr;
    logic [rtsf_pkg::RAW_W-1:0] dqr;
    logic [rtsf_pkg::RAW_W:0]   sum;
    dpq = (p >= q) ? p - q : q - p;
    dpr = (p >= r) ? p - r : r - p;
    dqr = (q >= r) ? q - r : r - q;
    if (dpq <= dpr && dpq <= dqr) begin
      sum = {1'b0, p} + {1'b0, q};
    end else if (dpr <= dpq && dpr <= dqr) begin
      sum = {1'b0, p} + {1'b0, r};
    end else begin
      sum = {1'b0, q} + {1'b0, r};
    end
    return sum[rtsf_pkg::RAW_W:1];
  endfunction

  // input capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= sample;
    end
  end

  assign press = {1'b0, s1.z1_reading} + rtsf_pkg::PRESS_OFFSET - {1'b0, s1.z2_reading};
  assign touched = s1.pen_down && (press >= threshold);

  always_comb begin
    meta_next.valid      = s1_valid;
    meta_next.touched    = touched;
    meta_next.pressure   = touched ? press : '0;
    meta_next.filtered_x = touched ? pair_mean(s1.x_first, s1.x_second, s1.x_third) : '0;
    meta_next.filtered_y = touched ? pair_mean(s1.y_first, s1.y_second, s1.y_third) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta <= '0;
    end else if (en) begin
      meta <= meta_next;
    end
  end

endmodule

### rtl/rtsf_axis_map.sv
`timescale 1ns / 1ps

module rtsf_axis_map (
  input  logic                           clk,
  input  logic                           en,
  input  logic [rtsf_pkg::RAW_W-1:0]     raw,
  input  logic [rtsf_pkg::RAW_W-1:0]     cal_low,
  input  logic [rtsf_pkg::RAW_W-1:0]     cal_high,
  input  logic [rtsf_pkg::TOP_W-1:0]     top,
  input  logic                           mirror,
  output logic [rtsf_pkg::TOP_W-1:0]     mapped
);

  typedef struct packed {
    logic [rtsf_pkg::RAW_W-1:0]     rem;
    logic [rtsf_pkg::TOP_W-1:0]     low;
    logic [rtsf_pkg::DIV_STEPS-1:0] quo;
    logic [rtsf_pkg::RAW_W-1:0]     span;
    logic                           ovf;
    logic                           neg;
    logic                           zero;
  } div_t;

  function automatic div_t div_step(input div_t d);
    div_t                     n;
    logic [rtsf_pkg::RAW_W:0] t;
    logic                     ge;
    n  = d;
    t  = {d.rem, d.low[rtsf_pkg::TOP_W-1]};
    ge = t >= {1'b0, d.span};
    n.rem = ge ? rtsf_pkg::RAW_W'(t - {1'b0, d.span}) : t[rtsf_pkg::RAW_W-1:0];
    n.low = {d.low[rtsf_pkg::TOP_W-2:0], 1'b0};
    n.quo = {d.quo[rtsf_pkg::DIV_STEPS-2:0], ge};
    return n;
  endfunction

  logic [rtsf_pkg::RAW_W:0]    diff;
  logic [rtsf_pkg::RAW_W:0]    span;
  logic [rtsf_pkg::RAW_W-1:0]  a1_diff_mag;
  logic                        a1_diff_neg;
  logic [rtsf_pkg::RAW_W-1:0]  a1_span_mag;
  logic                        a1_span_neg;
  logic [rtsf_pkg::PROD_W-1:0] a2_num;
  logic [rtsf_pkg::RAW_W-1:0]  a2_span;
  logic                        a2_neg;
  logic                        a2_zero;
  div_t                        dv0;
  div_t                        dv [1:rtsf_pkg::DIV_STEPS];
  div_t                        dl;
  logic [rtsf_pkg::TOP_W-1:0]  val;

  // signed offset and span, split into magnitude and sign
  assign diff = {1'b0, raw} - {1'b0, cal_low};
  assign span = {1'b0, cal_high} - {1'b0, cal_low};

  always_ff @(posedge clk) begin
    if (en) begin
      a1_diff_neg <= diff[rtsf_pkg::RAW_W];
      a1_diff_mag <= diff[rtsf_pkg::RAW_W] ? rtsf_pkg::RAW_W'(-diff) : diff[rtsf_pkg::RAW_W-1:0];
      a1_span_neg <= span[rtsf_pkg::RAW_W];
      a1_span_mag <= span[rtsf_pkg::RAW_W] ? rtsf_pkg::RAW_W'(-span) : span[rtsf_pkg::RAW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2_num  <= {{rtsf_pkg::TOP_W{1'b0}}, a1_diff_mag} * {{rtsf_pkg::RAW_W{1'b0}}, top};
      a2_span <= a1_span_mag;
      a2_neg  <= a1_diff_neg ^ a1_span_neg;
      a2_zero <= (a1_span_mag == '0);
    end
  end

  // quotient of at most DIV_STEPS bits, larger ones saturate
  always_comb begin
    dv0.rem  = a2_num[rtsf_pkg::PROD_W-1:rtsf_pkg::TOP_W];
    dv0.low  = a2_num[rtsf_pkg::TOP_W-1:0];
    dv0.quo  = '0;
    dv0.span = a2_span;
    dv0.ovf  = a2_num[rtsf_pkg::PROD_W-1:rtsf_pkg::TOP_W] >= a2_span;
    dv0.neg  = a2_neg;
    dv0.zero = a2_zero;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[1] <= div_step(dv0);
      for (int k = 2; k <= rtsf_pkg::DIV_STEPS; k++) begin
        dv[k] <= div_step(dv[k-1]);
      end
    end
  end

  assign dl = dv[rtsf_pkg::DIV_STEPS];

  // clamp to the screen
  always_comb begin
    if (dl.zero || dl.neg) begin
      val = '0;
    end else if (dl.ovf || dl.quo > top) begin
      val = top;
    end else begin
      val = dl.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mapped <= mirror ? top - val : val;
    end
  end

endmodule

### rtl/resistive_touch_sample_filter.sv
`timescale 1ns / 1ps

// Resistive touch sample filter. Each accepted item is one complete sample set
// and yields exactly one result: pressure is z1 + 4095 - z2, a touch needs the
// pen down and pressure at or above the threshold, each axis averages the
// closest pair of its three readings and maps that onto the screen through the
// calibration range, with clamping and optional mirroring. A new item can be
// accepted in every cycle while the result is not held; each item passes in
// turn through the input capture stage, the pressure and averaging stage, the
// offset and multiply stages, the 12-stage one-bit-per-cycle divider and the
// clamp stage. A stalled result holds the whole pipeline. Configuration writes
// are taken in every cycle and must only be issued while no item is in flight.
module resistive_touch_sample_filter (
  input logic         clk,
  input logic         rst,
  rtsf_in_if.sink     sample,
  rtsf_out_if.source  result,
  rtsf_cfg_if.sink    cfg
);

  rtsf_pkg::cfg_t    regs;
  rtsf_pkg::sample_t sample_in;
  rtsf_pkg::meta_t   front_meta;
  rtsf_pkg::meta_t   md [0:rtsf_pkg::AXIS_LAT-1];
  rtsf_pkg::meta_t   md_out;
  logic              en;
  logic [rtsf_pkg::TOP_W-1:0] x_map;
  logic [rtsf_pkg::TOP_W-1:0] y_map;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pressure_threshold <= rtsf_pkg::RST_PRESSURE_THRESHOLD;
      regs.x_cal_low          <= rtsf_pkg::RST_X_CAL_LOW;
      regs.x_cal_high         <= rtsf_pkg::RST_X_CAL_HIGH;
      regs.y_cal_low          <= rtsf_pkg::RST_Y_CAL_LOW;
      regs.y_cal_high         <= rtsf_pkg::RST_Y_CAL_HIGH;
      regs.mirror_x           <= 1'b0;
      regs.mirror_y           <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        rtsf_pkg::REG_PRESSURE_THRESHOLD: regs.pressure_threshold <= cfg.data;
        rtsf_pkg::REG_X_CAL_LOW:  regs.x_cal_low  <= cfg.data[rtsf_pkg::RAW_W-1:0];
        rtsf_pkg::REG_X_CAL_HIGH: regs.x_cal_high <= cfg.data[rtsf_pkg::RAW_W-1:0];
        rtsf_pkg::REG_Y_CAL_LOW:  regs.y_cal_low  <= cfg.data[rtsf_pkg::RAW_W-1:0];
        rtsf_pkg::REG_Y_CAL_HIGH: regs.y_cal_high <= cfg.data[rtsf_pkg::RAW_W-1:0];
        rtsf_pkg::REG_MIRROR_X:   regs.mirror_x   <= cfg.data[0];
        rtsf_pkg::REG_MIRROR_Y:   regs.mirror_y   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output item is held
  assign md_out       = md[rtsf_pkg::AXIS_LAT-1];
  assign en           = !md_out.valid || result.ready;
  assign sample.ready = en;

  always_comb begin
    sample_in.pen_down   = sample.pen_down;
    sample_in.z1_reading = sample.z1_reading;
    sample_in.z2_reading = sample.z2_reading;
    sample_in.x_first    = sample.x_first;
    sample_in.x_second   = sample.x_second;
    sample_in.x_third    = sample.x_third;
    sample_in.y_first    = sample.y_first;
    sample_in.y_second   = sample.y_second;
    sample_in.y_third    = sample.y_third;
  end

  rtsf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .sample    (sample_in),
    .threshold (regs.pressure_threshold),
    .meta      (front_meta)
  );

  rtsf_axis_map u_map_x (
    .clk      (clk),
    .en       (en),
    .raw      (front_meta.filtered_x),
    .cal_low  (regs.x_cal_low),
    .cal_high (regs.x_cal_high),
    .top      (rtsf_pkg::COL_TOP),
    .mirror   (regs.mirror_x),
    .mapped   (x_map)
  );

  rtsf_axis_map u_map_y (
    .clk      (clk),
    .en       (en),
    .raw      (front_meta.filtered_y),
    .cal_low  (regs.y_cal_low),
    .cal_high (regs.y_cal_high),
    .top      (rtsf_pkg::ROW_TOP),
    .mirror   (regs.mirror_y),
    .mapped   (y_map)
  );

  // item fields travel alongside the mapping pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rtsf_pkg::AXIS_LAT; i++) begin
        md[i] <= '0;
      end
    end else if (en) begin
      md[0] <= front_meta;
      for (int i = 1; i < rtsf_pkg::AXIS_LAT; i++) begin
        md[i] <= md[i-1];
      end
    end
  end

  assign result.valid      = md_out.valid;
  assign result.touched    = md_out.touched;
  assign result.pressure   = md_out.pressure;
  assign result.filtered_x = md_out.filtered_x;
  assign result.filtered_y = md_out.filtered_y;
  assign result.screen_x   = md_out.touched ? x_map[rtsf_pkg::SX_W-1:0] : '0;
  assign result.screen_y   = md_out.touched ? y_map[rtsf_pkg::SY_W-1:0] : '0;

endmodule

### tb/resistive_touch_sample_filter_tb.sv
`timescale 1ns / 1ps

module resistive_touch_sample_filter_tb;
  import rtsf_pkg::*;

  localparam int IDLE_PCT     = 35;
  localparam int PHASE_ITEMS  = 270;
  localparam int DRAIN_CYCLES = AXIS_LAT + 9;
  localparam int STALL_LIMIT  = 2000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic               touched;
    logic [SX_W-1:0]    screen_x;
    logic [SY_W-1:0]    screen_y;
    logic [RAW_W-1:0]   filtered_x;
    logic [RAW_W-1:0]   filtered_y;
    logic [PRESS_W-1:0] pressure;
  } touch_result_t;

  logic clk = 1'b0;
  logic rst;

  rtsf_in_if  sample_ch ();
  rtsf_out_if result_ch ();
  rtsf_cfg_if cfg_ch ();

  resistive_touch_sample_filter dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cfg_t          cur_cfg;
  sample_t       pending_samples[$];
  touch_result_t expected_touches[$];
  sample_t       next_sample;
  sample_t       taken_sample;
  touch_result_t want;
  logic          sample_taken = 1'b0;
  logic          calm = 1'b0;
  int            idle_cycles = 0;
  int            mismatch_count = 0;

  function automatic logic [RAW_W-1:0] closest_pair_mean(input logic [RAW_W-1:0] p, q, r);
    int d_pq, d_pr, d_qr;
    d_pq = (p >= q) ? int'(p) - int'(q) : int'(q) - int'(p);
    d_pr = (p >= r) ? int'(p) - int'(r) : int'(r) - int'(p);
    d_qr = (q >= r) ? int'(q) - int'(r) : int'(r) - int'(q);
    if (d_pq <= d_pr && d_pq <= d_qr) begin
      return RAW_W'((int'(p) + int'(q)) >> 1);
    end
    if (d_pr <= d_pq && d_pr <= d_qr) begin
      return RAW_W'((int'(p) + int'(r)) >> 1);
    end
    return RAW_W'((int'(q) + int'(r)) >> 1);
  endfunction

  function automatic int scale_to_screen(input logic [RAW_W-1:0] raw, lo, hi,
                                         input int size, input logic mirror);
    longint top, span, v;
    top  = longint'(size) - 1;
    span = longint'(hi) - longint'(lo);
    v    = 0;
    if (span != 0) begin
      v = (longint'(raw) - longint'(lo)) * top / span;
    end
    if (v < 0) begin
      v = 0;
    end
    if (v > top) begin
      v = top;
    end
    if (mirror) begin
      v = top - v;
    end
    return int'(v);
  endfunction

  function automatic touch_result_t predict_touch(input sample_t s);
    touch_result_t r;
    int press;
    r = '0;
    press = int'(s.z1_reading) + int'(PRESS_OFFSET) - int'(s.z2_reading);
    if (s.pen_down && press >= int'(cur_cfg.pressure_threshold)) begin
      r.touched    = 1'b1;
      r.pressure   = PRESS_W'(press);
      r.filtered_x = closest_pair_mean(s.x_first, s.x_second, s.x_third);
      r.filtered_y = closest_pair_mean(s.y_first, s.y_second, s.y_third);
      r.screen_x   = SX_W'(scale_to_screen(r.filtered_x, cur_cfg.x_cal_low,
                                           cur_cfg.x_cal_high, SCREEN_COLS, cur_cfg.mirror_x));
      r.screen_y   = SY_W'(scale_to_screen(r.filtered_y, cur_cfg.y_cal_low,
                                           cur_cfg.y_cal_high, SCREEN_ROWS, cur_cfg.mirror_y));
    end
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] near_reading(input int centre, input int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) begin
      v = 0;
    end
    if (v > 4095) begin
      v = 4095;
    end
    return RAW_W'(v);
  endfunction

  function automatic int pick_spread();
    case ($urandom_range(3))
      0: return 0;
      1: return 3;
      2: return 40;
      default: return 600;
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int target, lo, hi, centre, spread;
    if ($urandom_range(9) < 2) begin
      s.pen_down   = 1'($urandom_range(1));
      s.z1_reading = RAW_W'($urandom_range(4095));
      s.z2_reading = RAW_W'($urandom_range(4095));
      s.x_first    = RAW_W'($urandom_range(4095));
      s.x_second   = RAW_W'($urandom_range(4095));
      s.x_third    = RAW_W'($urandom_range(4095));
      s.y_first    = RAW_W'($urandom_range(4095));
      s.y_second   = RAW_W'($urandom_range(4095));
      s.y_third    = RAW_W'($urandom_range(4095));
      return s;
    end
    s.pen_down = ($urandom_range(9) != 0);
    // aim the pressure around the threshold half of the time
    if ($urandom_range(1)) begin
      target = int'(cur_cfg.pressure_threshold) + int'($urandom_range(16)) - 8;
    end else begin
      target = int'($urandom_range(8190));
    end
    if (target < 0) begin
      target = 0;
    end
    if (target > 8190) begin
      target = 8190;
    end
    lo = (target < 4095) ? 4095 - target : 0;
    hi = (target > 4095) ? 8190 - target : 4095;
    s.z2_reading = RAW_W'($urandom_range(hi, lo));
    s.z1_reading = RAW_W'(target - 4095 + int'(s.z2_reading));
    centre = int'($urandom_range(4095));
    spread = pick_spread();
    s.x_first  = near_reading(centre, spread);
    s.x_second = near_reading(centre, spread);
    s.x_third  = near_reading(centre, spread);
    centre = int'($urandom_range(4095));
    spread = pick_spread();
    s.y_first  = near_reading(centre, spread);
    s.y_second = near_reading(centre, spread);
    s.y_third  = near_reading(centre, spread);
    return s;
  endfunction

  task automatic add_sample(input logic pen, input int z1, z2, x1, x2, x3, y1, y2, y3);
    sample_t s;
    s.pen_down   = pen;
    s.z1_reading = RAW_W'(z1);
    s.z2_reading = RAW_W'(z2);
    s.x_first    = RAW_W'(x1);
    s.x_second   = RAW_W'(x2);
    s.x_third    = RAW_W'(x3);
    s.y_first    = RAW_W'(y1);
    s.y_second   = RAW_W'(y2);
    s.y_third    = RAW_W'(y3);
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_ch.valid || expected_touches.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    repeat (count) pending_samples.push_back(random_sample());
    wait_drained();
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PRESSURE_THRESHOLD: cur_cfg.pressure_threshold = val;
      REG_X_CAL_LOW:          cur_cfg.x_cal_low = val[RAW_W-1:0];
      REG_X_CAL_HIGH:         cur_cfg.x_cal_high = val[RAW_W-1:0];
      REG_Y_CAL_LOW:          cur_cfg.y_cal_low = val[RAW_W-1:0];
      REG_Y_CAL_HIGH:         cur_cfg.y_cal_high = val[RAW_W-1:0];
      REG_MIRROR_X:           cur_cfg.mirror_x = val[0];
      REG_MIRROR_Y:           cur_cfg.mirror_y = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_DATA_W-1:0] thr, xl, xh, yl, yh, mx, my);
    write_reg(REG_PRESSURE_THRESHOLD, thr);
    write_reg(REG_X_CAL_LOW, xl);
    write_reg(REG_X_CAL_HIGH, xh);
    write_reg(REG_Y_CAL_LOW, yl);
    write_reg(REG_Y_CAL_HIGH, yh);
    write_reg(REG_MIRROR_X, mx);
    write_reg(REG_MIRROR_Y, my);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_v, act_v);
    if (act_v !== exp_v) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_taken) begin
      if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        next_sample = pending_samples.pop_front();
        sample_ch.valid      <= 1'b1;
        sample_ch.pen_down   <= next_sample.pen_down;
        sample_ch.z1_reading <= next_sample.z1_reading;
        sample_ch.z2_reading <= next_sample.z2_reading;
        sample_ch.x_first    <= next_sample.x_first;
        sample_ch.x_second   <= next_sample.x_second;
        sample_ch.x_third    <= next_sample.x_third;
        sample_ch.y_first    <= next_sample.y_first;
        sample_ch.y_second   <= next_sample.y_second;
        sample_ch.y_third    <= next_sample.y_third;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
    result_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // monitor
  always @(posedge clk) begin
    sample_taken <= sample_ch.valid && sample_ch.ready;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_touches.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual touched %0b x %0d y %0d",
                   $time, result_ch.touched, result_ch.screen_x, result_ch.screen_y);
        end else begin
          want = expected_touches.pop_front();
          check_field("touched", 16'(want.touched), 16'(result_ch.touched));
          check_field("screen_x", 16'(want.screen_x), 16'(result_ch.screen_x));
          check_field("screen_y", 16'(want.screen_y), 16'(result_ch.screen_y));
          check_field("filtered_x", 16'(want.filtered_x), 16'(result_ch.filtered_x));
          check_field("filtered_y", 16'(want.filtered_y), 16'(result_ch.filtered_y));
          check_field("pressure", 16'(want.pressure), 16'(result_ch.pressure));
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        taken_sample.pen_down   = sample_ch.pen_down;
        taken_sample.z1_reading = sample_ch.z1_reading;
        taken_sample.z2_reading = sample_ch.z2_reading;
        taken_sample.x_first    = sample_ch.x_first;
        taken_sample.x_second   = sample_ch.x_second;
        taken_sample.x_third    = sample_ch.x_third;
        taken_sample.y_first    = sample_ch.y_first;
        taken_sample.y_second   = sample_ch.y_second;
        taken_sample.y_third    = sample_ch.y_third;
        expected_touches.push_back(predict_touch(taken_sample));
      end
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    cur_cfg.pressure_threshold = RST_PRESSURE_THRESHOLD;
    cur_cfg.x_cal_low  = RST_X_CAL_LOW;
    cur_cfg.x_cal_high = RST_X_CAL_HIGH;
    cur_cfg.y_cal_low  = RST_Y_CAL_LOW;
    cur_cfg.y_cal_high = RST_Y_CAL_HIGH;
    cur_cfg.mirror_x   = 1'b0;
    cur_cfg.mirror_y   = 1'b0;
    rst = 1'b1;
    sample_ch.valid      = 1'b0;
    sample_ch.pen_down   = 1'b0;
    sample_ch.z1_reading = '0;
    sample_ch.z2_reading = '0;
    sample_ch.x_first    = '0;
    sample_ch.x_second   = '0;
    sample_ch.x_third    = '0;
    sample_ch.y_first    = '0;
    sample_ch.y_second   = '0;
    sample_ch.y_third    = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_PRESSURE_THRESHOLD;
    cfg_ch.data          = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset calibration
    add_sample(1'b0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_sample(1'b1, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    add_sample(1'b1, 4095, 0, 0, 0, 0, 0, 0, 0);
    add_sample(1'b1, 0, 4095, 1000, 1000, 1000, 1000, 1000, 1000);
    // pressure on and just under the threshold
    add_sample(1'b1, 0, 3695, 1000, 1001, 3000, 2000, 2001, 100);
    add_sample(1'b1, 0, 3696, 1000, 1001, 3000, 2000, 2001, 100);
    add_sample(1'b0, 4095, 0, 1500, 1500, 1500, 1500, 1500, 1500);
    // pair ties
    add_sample(1'b1, 3000, 100, 100, 110, 120, 2000, 2010, 2020);
    add_sample(1'b1, 3000, 100, 100, 200, 150, 3000, 2900, 2950);
    add_sample(1'b1, 3000, 100, 500, 500, 500, 7, 8, 9);
    add_sample(1'b1, 3000, 100, 201, 202, 4000, 241, 244, 0);
    add_sample(1'b1, 3000, 100, 10, 4000, 12, 4095, 0, 4094);
    add_sample(1'b1, 3000, 100, 0, 3000, 3001, 4095, 1, 2);
    // calibration end points and clamping
    add_sample(1'b1, 2000, 1000, 200, 200, 200, 240, 240, 240);
    add_sample(1'b1, 2000, 1000, 3700, 3700, 3700, 3800, 3800, 3800);
    add_sample(1'b1, 2000, 1000, 199, 199, 199, 3801, 3801, 3801);
    add_sample(1'b1, 2000, 1000, 3701, 3702, 3703, 239, 238, 237);
    add_sample(1'b1, 'hAAA, 'h555, 'hAAA, 'h555, 'hAAB, 'h555, 'hAAA, 'h554);
    add_sample(1'b1, 'h555, 'hAAA, 'h555, 'hAAA, 'h556, 'hAAA, 'h555, 'hAAB);
    run_random(PHASE_ITEMS);

    write_all(13'd0, 13'd0, 13'd4095, 13'd0, 13'd4095, 13'd1, 13'd1);
    calm = 1'b1;
    run_random(PHASE_ITEMS);
    calm = 1'b0;

    // reversed calibration
    write_all(13'd4000, 13'd4095, 13'd0, 13'd3000, 13'd500, 13'd0, 13'd1);
    run_random(PHASE_ITEMS);

    write_all(13'd8190, 13'd200, 13'd3700, 13'd240, 13'd3800, 13'd1, 13'd0);
    run_random(PHASE_ITEMS);

    // zero-width calibration, upper data bit dropped by the 12-bit registers
    write_reg(REG_UNUSED, 13'd0);
    write_all(13'd100, 13'h1800, 13'h0800, 13'd0, 13'd0, 13'd0, 13'd1);
    run_random(PHASE_ITEMS);

    repeat (2) begin
      write_all(CFG_DATA_W'($urandom_range(1) ? $urandom_range(4200) : $urandom_range(8190)),
                CFG_DATA_W'($urandom_range(8191)), CFG_DATA_W'($urandom_range(8191)),
                CFG_DATA_W'($urandom_range(8191)), CFG_DATA_W'($urandom_range(8191)),
                CFG_DATA_W'($urandom_range(8191)), CFG_DATA_W'($urandom_range(8191)));
      run_random(PHASE_ITEMS);
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/rtsf_pkg.sv
rtl/rtsf_in_if.sv
rtl/rtsf_out_if.sv
rtl/rtsf_cfg_if.sv
rtl/rtsf_front.sv
rtl/rtsf_axis_map.sv
rtl/resistive_touch_sample_filter.sv
tb/resistive_touch_sample_filter_tb.sv
